// ===== design/iir8_pkg.sv =====
// Package for the eighth-order IIR filter: widths, cell control struct and
// arithmetic helpers (magnitude, rounding, coefficient slot select).
// No dependencies.
`default_nettype none

package iir8_pkg;

    localparam int unsigned ORDER      = 8;
    localparam int unsigned NUM_WORDS  = 8;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned VEC_W      = NUM_WORDS * WORD_W;
    localparam int unsigned COEF_W     = 30;
    localparam int unsigned X_W        = 24;
    localparam int unsigned Y_W        = 40;
    localparam int unsigned D_W        = 64;
    localparam int unsigned PBX_W      = COEF_W + X_W - 1;
    localparam int unsigned BX_W       = 38;
    localparam int unsigned HI_W       = Y_W - 24;
    localparam int unsigned PH_W       = COEF_W + HI_W;
    localparam int unsigned PL_W       = COEF_W + 24;
    localparam int unsigned AY_W       = 47;
    localparam int unsigned T_W        = 48;
    localparam int unsigned A_BASE     = ORDER + 1;

    localparam logic signed [D_W:0] Y_MAX = 65'sd549755813887;
    localparam logic signed [D_W:0] Y_MIN = -65'sd549755813888;

    typedef logic [VEC_W-1:0] t_coef_vec;

    typedef struct packed {
        logic mul_bx;
        logic rnd_bx;
        logic mul_ay;
        logic calc_t;
        logic upd;
    } t_ctrl;

    function automatic logic signed [COEF_W-1:0] coef_slot(input t_coef_vec v,
                                                           input int unsigned k);
        return v[k*COEF_W +: COEF_W];
    endfunction

    function automatic logic [COEF_W-1:0] mag_coef(input logic signed [COEF_W-1:0] v);
        return v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
    endfunction

    function automatic logic [X_W-1:0] mag_x(input logic signed [X_W-1:0] v);
        return v[X_W-1] ? X_W'(-v) : X_W'(v);
    endfunction

    function automatic logic [Y_W-1:0] mag_y(input logic signed [Y_W-1:0] v);
        return v[Y_W-1] ? Y_W'(-v) : Y_W'(v);
    endfunction

    // b*x magnitude from Q.24 to Q.8, ties away from zero, then signed
    function automatic logic signed [BX_W-1:0] round_bx(input logic [PBX_W-1:0] p,
                                                        input logic neg);
        logic [PBX_W:0]  s;
        logic [BX_W-1:0] r;
        s = {1'b0, p} + (PBX_W+1)'(32768);
        r = s[PBX_W:16];
        return neg ? $signed(BX_W'(-r)) : $signed(r);
    endfunction

endpackage

`default_nettype wire

// ===== design/iir_filter_order8.sv =====
// Top level of the eighth-order IIR filter: coefficient registers, output
// stage, sequencer and the chain of eight iir8_cell taps. Uses iir8_pkg.
//
// Usage:
//   Input channel i_valid/o_ready carries one signed 24-bit sample per item.
//   Output channel o_valid/i_ready carries o_filtered (Q31.8, saturated) and
//   o_saturated, set when the output or any delay word clamped for that item.
//   Coefficients are written through i_cfg_we/i_cfg_index/i_cfg_data; the
//   user must write them only while the filter is idle, which the block does
//   not enforce. Indices above 7 are ignored. After a sample is accepted, the
//   sequencer steps through b*x multiply, rounding and output sum, a*y
//   multiply, tap sum and delay update, where the result is registered. The
//   sequencer takes a new sample in the update cycle; the a*y feedback on the
//   current output keeps the next item from starting any earlier.
//   A full output register that is not taken holds the sequencer before the
//   delay update, so no result is lost; the input then waits as well.
//   Reset clears coefficients and delay words and empties the output register.
`default_nettype none

module iir_filter_order8 (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [iir8_pkg::IDX_W-1:0]          i_cfg_index,
    input  wire logic [iir8_pkg::WORD_W-1:0]         i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [iir8_pkg::X_W-1:0]     i_sample,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [iir8_pkg::Y_W-1:0]          o_filtered,
    output logic                                     o_saturated
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BX   = 3'd1;
    localparam logic [2:0] ST_Y    = 3'd2;
    localparam logic [2:0] ST_AY   = 3'd3;
    localparam logic [2:0] ST_TT   = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;

    logic [2:0]                           r_state;
    logic [2:0]                           n_state;
    logic [iir8_pkg::WORD_W-1:0]          r_coef [iir8_pkg::NUM_WORDS];
    iir8_pkg::t_coef_vec                  coef_vec;
    logic signed [iir8_pkg::X_W-1:0]      r_x;
    logic [iir8_pkg::PBX_W-1:0]           r_pb0;
    logic                                 r_b0neg;
    logic signed [iir8_pkg::Y_W-1:0]      r_y;
    logic                                 r_ysat;
    logic                                 r_out_valid;
    logic signed [iir8_pkg::Y_W-1:0]      r_filtered;
    logic                                 r_sat;

    logic                                 in_acc;
    logic                                 out_free;
    iir8_pkg::t_ctrl                      ctrl;
    logic signed [iir8_pkg::COEF_W-1:0]   b0;
    logic signed [iir8_pkg::BX_W-1:0]     bx0;
    logic signed [iir8_pkg::D_W:0]        y_sum;
    logic signed [iir8_pkg::Y_W-1:0]      n_y;
    logic                                 n_ysat;
    logic signed [iir8_pkg::D_W-1:0]      d_tap  [iir8_pkg::ORDER+1];
    logic [iir8_pkg::ORDER-1:0]           tap_sat;

    always_comb begin
        for (int i = 0; i < iir8_pkg::NUM_WORDS; i++) begin
            coef_vec[i*iir8_pkg::WORD_W +: iir8_pkg::WORD_W] = r_coef[i];
        end
    end

    assign o_ready  = (r_state == ST_IDLE) || (r_state == ST_UPD);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        ctrl.mul_bx = r_state == ST_BX;
        ctrl.rnd_bx = r_state == ST_Y;
        ctrl.mul_ay = r_state == ST_AY;
        ctrl.calc_t = r_state == ST_TT;
        ctrl.upd    = r_state == ST_UPD;
    end

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = in_acc ? ST_BX : ST_IDLE;
            ST_BX:   n_state = ST_Y;
            ST_Y:    n_state = ST_AY;
            ST_AY:   n_state = ST_TT;
            ST_TT:   n_state = out_free ? ST_UPD : ST_TT;
            ST_UPD:  n_state = in_acc ? ST_BX : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < iir8_pkg::NUM_WORDS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < iir8_pkg::IDX_W'(iir8_pkg::NUM_WORDS))) begin
            r_coef[i_cfg_index[$clog2(iir8_pkg::NUM_WORDS)-1:0]] <= i_cfg_data;
        end
    end

    // output sum: b0*x + d0, clamped to 40 bits
    always_comb begin
        b0     = iir8_pkg::coef_slot(coef_vec, 0);
        bx0    = iir8_pkg::round_bx(r_pb0, r_b0neg);
        y_sum  = (iir8_pkg::D_W+1)'(bx0) + (iir8_pkg::D_W+1)'(d_tap[0]);
        n_ysat = 1'b0;
        if (y_sum > iir8_pkg::Y_MAX) begin
            n_y    = iir8_pkg::Y_W'(iir8_pkg::Y_MAX);
            n_ysat = 1'b1;
        end else if (y_sum < iir8_pkg::Y_MIN) begin
            n_y    = iir8_pkg::Y_W'(iir8_pkg::Y_MIN);
            n_ysat = 1'b1;
        end else begin
            n_y = y_sum[iir8_pkg::Y_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_sample;
        end
        if (ctrl.mul_bx) begin
            r_pb0   <= iir8_pkg::PBX_W'(iir8_pkg::mag_coef(b0) * iir8_pkg::mag_x(r_x));
            r_b0neg <= b0[iir8_pkg::COEF_W-1] ^ r_x[iir8_pkg::X_W-1];
        end
        if (ctrl.rnd_bx) begin
            r_y    <= n_y;
            r_ysat <= n_ysat;
        end
        if (ctrl.upd) begin
            r_filtered <= r_y;
            r_sat      <= r_ysat | (|tap_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.upd) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign d_tap[iir8_pkg::ORDER] = '0;

    for (genvar g = 0; g < iir8_pkg::ORDER; g++) begin : g_tap
        iir8_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_coef_b (iir8_pkg::coef_slot(coef_vec, g + 1)),
            .i_coef_a (iir8_pkg::coef_slot(coef_vec, iir8_pkg::A_BASE + g)),
            .i_x      (r_x),
            .i_y      (r_y),
            .i_d_next (d_tap[g+1]),
            .o_d      (d_tap[g]),
            .o_sat    (tap_sat[g])
        );
    end

    assign o_valid     = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_sat;

    a_upd_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPD |-> $past(!r_out_valid || i_ready))
        else $error("delay update entered with output register occupied");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ST_BX)
        else $error("accepted item did not start the multiply stage");

    a_result_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_UPD))
        else $error("result appeared without a delay update");

endmodule

`default_nettype wire

// ===== design/iir8_cell.sv =====
// One tap of the transposed-form chain: holds one delay word, forms
// b*x - a*y and adds the neighbour's delay word. Uses iir8_pkg.
`default_nettype none

module iir8_cell (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire iir8_pkg::t_ctrl                      i_ctrl,
    input  wire logic signed [iir8_pkg::COEF_W-1:0]   i_coef_b,
    input  wire logic signed [iir8_pkg::COEF_W-1:0]   i_coef_a,
    input  wire logic signed [iir8_pkg::X_W-1:0]      i_x,
    input  wire logic signed [iir8_pkg::Y_W-1:0]      i_y,
    input  wire logic signed [iir8_pkg::D_W-1:0]      i_d_next,
    output logic signed [iir8_pkg::D_W-1:0]           o_d,
    output logic                                      o_sat
);

    logic [iir8_pkg::PBX_W-1:0]        r_pbx;
    logic                              r_bxneg;
    logic signed [iir8_pkg::BX_W-1:0]  r_bx;
    logic [iir8_pkg::PH_W-1:0]         r_ph;
    logic [iir8_pkg::PL_W-1:0]         r_pl;
    logic                              r_ayneg;
    logic signed [iir8_pkg::T_W-1:0]   r_t;
    logic signed [iir8_pkg::D_W-1:0]   r_d;

    logic [iir8_pkg::COEF_W-1:0]       mag_b;
    logic [iir8_pkg::COEF_W-1:0]       mag_a;
    logic [iir8_pkg::Y_W-1:0]          mag_yv;
    logic [iir8_pkg::PL_W:0]           pl_rnd;
    logic [iir8_pkg::PH_W:0]           ay_sum;
    logic [iir8_pkg::AY_W-1:0]         ay_mag;
    logic signed [iir8_pkg::AY_W-1:0]  ay;
    logic signed [iir8_pkg::T_W-1:0]   n_t;
    logic signed [iir8_pkg::D_W:0]     d_sum;
    logic signed [iir8_pkg::D_W-1:0]   n_d;
    logic                              d_ovf;

    always_comb begin
        mag_b  = iir8_pkg::mag_coef(i_coef_b);
        mag_a  = iir8_pkg::mag_coef(i_coef_a);
        mag_yv = iir8_pkg::mag_y(i_y);
        pl_rnd = {1'b0, r_pl} + (iir8_pkg::PL_W+1)'(24'h800000);
        ay_sum = (iir8_pkg::PH_W+1)'(r_ph) + (iir8_pkg::PH_W+1)'(pl_rnd[iir8_pkg::PL_W:24]);
        ay_mag = iir8_pkg::AY_W'(ay_sum);
        ay     = r_ayneg ? $signed(iir8_pkg::AY_W'(-ay_mag)) : $signed(ay_mag);
        n_t    = iir8_pkg::T_W'(r_bx) - iir8_pkg::T_W'(ay);
        d_sum  = (iir8_pkg::D_W+1)'(i_d_next) + (iir8_pkg::D_W+1)'(r_t);
        d_ovf  = d_sum[iir8_pkg::D_W] != d_sum[iir8_pkg::D_W-1];
        if (d_ovf) begin
            n_d = d_sum[iir8_pkg::D_W] ? {1'b1, {(iir8_pkg::D_W-1){1'b0}}}
                                       : {1'b0, {(iir8_pkg::D_W-1){1'b1}}};
        end else begin
            n_d = d_sum[iir8_pkg::D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_bx) begin
            r_pbx   <= iir8_pkg::PBX_W'(mag_b * iir8_pkg::mag_x(i_x));
            r_bxneg <= i_coef_b[iir8_pkg::COEF_W-1] ^ i_x[iir8_pkg::X_W-1];
        end
        if (i_ctrl.rnd_bx) begin
            r_bx <= iir8_pkg::round_bx(r_pbx, r_bxneg);
        end
        if (i_ctrl.mul_ay) begin
            r_ph    <= iir8_pkg::PH_W'(mag_a * mag_yv[iir8_pkg::Y_W-1:24]);
            r_pl    <= iir8_pkg::PL_W'(mag_a * mag_yv[23:0]);
            r_ayneg <= i_coef_a[iir8_pkg::COEF_W-1] ^ i_y[iir8_pkg::Y_W-1];
        end
        if (i_ctrl.calc_t) begin
            r_t <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else if (i_ctrl.upd) begin
            r_d <= n_d;
        end
    end

    assign o_d   = r_d;
    assign o_sat = i_ctrl.upd & d_ovf;

endmodule

`default_nettype wire
